// File: src/lrtd_pkg.sv
// Shared types and constants for the latching relay timer driver.
// Depends on nothing; imported by lrtd_relay, latching_relay_timer_driver, lrtd_checker and the testbench.
`default_nettype none

package lrtd_pkg;

    // Request codes carried in s_tuser.
    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_ON     = 3'd1,
        REQ_OFF    = 3'd2,
        REQ_TOGGLE = 3'd3,
        REQ_TIMER  = 3'd4
    } req_t;

    // Relay modes. The fourth code is never produced.
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_TIMED = 2'd2
    } mode_t;

    localparam int unsigned SECONDS_W = 16;
    localparam int unsigned MASK_W    = 2;
    localparam int unsigned PRESCALE_W = 4;
    localparam logic [PRESCALE_W-1:0] TICKS_PER_SECOND_LAST = 4'd9;

    // Control sent from the top level to every relay cell.
    typedef struct packed {
        logic                 tick;
        logic                 second_strobe;
        logic                 cmd_sel;
        logic [2:0]           req;
        logic [SECONDS_W-1:0] seconds;
    } relay_ctl_t;

    // Coil pulses that one relay cell asks for on a tick.
    typedef struct packed {
        logic on_coil;
        logic off_coil;
    } coil_t;

endpackage

`default_nettype wire

// File: src/latching_relay_timer_driver.sv
// Latching relay timer driver: input register, tick prescaler, relay cells
// and result register. Depends on lrtd_pkg and lrtd_relay.
//
// Usage:
// Items arrive on the s_ channel. s_tuser carries the request kind (tick,
// turn on, turn off, toggle, set timer); s_tdata carries the relay index and
// the timer length in seconds. Each tick stands for 100 ms. Commands change
// the addressed relay and produce no result. Every tick produces exactly one
// result item on the m_ channel, holding an on-coil mask and an off-coil
// mask; a set bit means that coil is pulsed for this tick.
// Every tenth tick, timed relays count down one second and turn off when
// their countdown reaches zero.
// An accepted item is captured in the input register and handled from there;
// a tick's result is captured in the result register, which drives m_tvalid.
// The block takes one item per cycle unless a tick is held back; the relay
// update logic between the input and result registers is combinational.
// When the receiver stalls, the result register holds its item; commands keep
// flowing, and only a tick that meets a full, stalled result register waits
// in the input register, which then deasserts s_tready.
// Reset (aresetn low, synchronous) turns all relays off, clears countdowns,
// pending pulses and the prescaler, and empties both registers.
`default_nettype none

module latching_relay_timer_driver
    import lrtd_pkg::*;
#(
    parameter int RELAY_COUNT = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [0] relay_index, [16:1] seconds, zero pad
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [1:0] on_coil_mask, [3:2] off_coil_mask
);

    // Input register. It only needs a valid bit reset.
    logic                 in_valid_reg, in_valid_next;
    logic [2:0]           in_req_reg;
    logic                 in_idx_reg;
    logic [SECONDS_W-1:0] in_secs_reg;

    logic in_tick;
    logic advance;
    logic load_in;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] on_mask_reg, off_mask_reg;
    logic [MASK_W-1:0] on_mask_next, off_mask_next;

    // Tick prescaler: counts ticks within the current second.
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic                  second_strobe;

    relay_ctl_t ctl;
    coil_t      coils [RELAY_COUNT];

    assign in_tick = (in_req_reg == REQ_TICK);

    // A command never waits; a tick waits only if its result has nowhere to go.
    assign advance  = in_valid_reg && (!in_tick || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (load_in) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    assign second_strobe = (prescale_reg == TICKS_PER_SECOND_LAST);

    always_comb begin
        prescale_next = prescale_reg;
        if (advance && in_tick) begin
            prescale_next = second_strobe ? '0 : prescale_reg + PRESCALE_W'(1);
        end
    end

    // Commands addressed past the end of the bank are dropped here.
    always_comb begin
        ctl.tick          = advance && in_tick;
        ctl.second_strobe = second_strobe;
        ctl.cmd_sel       = advance && !in_tick && (32'(in_idx_reg) < RELAY_COUNT);
        ctl.req           = in_req_reg;
        ctl.seconds       = in_secs_reg;
    end

    for (genvar r = 0; r < RELAY_COUNT; r++) begin : g_relay
        relay_ctl_t ctl_r;
        always_comb begin
            ctl_r         = ctl;
            ctl_r.cmd_sel = ctl.cmd_sel && (32'(in_idx_reg) == r);
        end
        lrtd_relay u_relay (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl_r),
            .coil    (coils[r])
        );
    end

    // Only the first relays fit in the output masks.
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < RELAY_COUNT) begin : g_used
            assign on_mask_next[b]  = coils[b].on_coil;
            assign off_mask_next[b] = coils[b].off_coil;
        end else begin : g_unused
            assign on_mask_next[b]  = 1'b0;
            assign off_mask_next[b] = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_tick) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prescale_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            prescale_reg  <= prescale_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_req_reg  <= s_tuser;
            in_idx_reg  <= s_tdata[0];
            in_secs_reg <= s_tdata[SECONDS_W:1];
        end
        if (advance && in_tick) begin
            on_mask_reg  <= on_mask_next;
            off_mask_reg <= off_mask_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, off_mask_reg, on_mask_reg};

    // A relay is never pulsed on both coils in the same tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((on_mask_reg & off_mask_reg) == '0))
        else $error("on and off coil pulsed together");

    // The prescaler wraps after the tenth tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        prescale_reg <= TICKS_PER_SECOND_LAST)
        else $error("prescaler out of range");

    // A tick held back by a stalled result stays in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(in_req_reg) && $stable(in_secs_reg)
             && $stable(in_idx_reg)))
        else $error("stalled input item lost");

    // Only a tick may load a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && $past(!in_valid_reg)) |=> !out_valid_reg || $past(in_tick))
        else $error("result loaded without a tick");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// File: src/lrtd_relay.sv
// One relay cell: mode, countdown and pending flag with their update logic.
// Depends on lrtd_pkg.
`default_nettype none

module lrtd_relay
    import lrtd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire relay_ctl_t ctl,
    output coil_t           coil
);

    mode_t                mode_reg, mode_next;
    logic [SECONDS_W-1:0] countdown_reg, countdown_next;
    logic                 pending_reg, pending_next;

    always_comb begin
        mode_t mode_tmp;
        logic  pend_tmp;
        mode_tmp       = mode_reg;
        pend_tmp       = pending_reg;
        mode_next      = mode_reg;
        countdown_next = countdown_reg;
        pending_next   = pending_reg;
        coil           = '0;
        if (ctl.tick) begin
            // The second boundary is applied before the coils are evaluated.
            if (ctl.second_strobe && mode_reg == MODE_TIMED && countdown_reg != '0) begin
                countdown_next = countdown_reg - SECONDS_W'(1);
                if (countdown_reg == SECONDS_W'(1)) begin
                    mode_tmp = MODE_OFF;
                    pend_tmp = 1'b1;
                end
            end
            if (pend_tmp) begin
                if (mode_tmp == MODE_ON || mode_tmp == MODE_TIMED) begin
                    coil.on_coil = 1'b1;
                end else begin
                    coil.off_coil = 1'b1;
                end
            end
            mode_next    = mode_tmp;
            pending_next = 1'b0;
        end else if (ctl.cmd_sel) begin
            case (ctl.req)
                REQ_ON: begin
                    mode_next    = MODE_ON;
                    pending_next = 1'b1;
                end
                REQ_OFF: begin
                    mode_next    = MODE_OFF;
                    pending_next = 1'b1;
                end
                REQ_TOGGLE: begin
                    mode_next    = (mode_reg == MODE_ON) ? MODE_OFF : MODE_ON;
                    pending_next = 1'b1;
                end
                REQ_TIMER: begin
                    pending_next = 1'b1;
                    if (ctl.seconds == '0) begin
                        mode_next = MODE_OFF;
                    end else if (ctl.seconds == SECONDS_W'(1)) begin
                        mode_next = MODE_ON;
                    end else begin
                        mode_next      = MODE_TIMED;
                        countdown_next = ctl.seconds;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_OFF;
            countdown_reg <= '0;
            pending_reg   <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            countdown_reg <= countdown_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/lrtd_checker.sv
// Checker for the latching relay timer driver: watches both stream channels,
// predicts coil masks for every accepted tick and compares them in order.
// Depends on lrtd_pkg for request codes, relay modes and field widths.
`timescale 1ns / 1ps

module lrtd_checker
    import lrtd_pkg::*;
#(
    parameter int RELAY_COUNT = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          error_count,
    output int          coils_outstanding
);

    typedef struct packed {
        logic [MASK_W-1:0] off_mask;
        logic [MASK_W-1:0] on_mask;
    } coil_masks_t;

    coil_masks_t          coil_pulse_q[$];
    mode_t                relay_state[RELAY_COUNT];
    logic [SECONDS_W-1:0] secs_left[RELAY_COUNT];
    logic                 pulse_due[RELAY_COUNT];
    logic [PRESCALE_W-1:0] tick_phase;

    task automatic clear_relays();
        for (int r = 0; r < RELAY_COUNT; r++) begin
            relay_state[r] = MODE_OFF;
            secs_left[r]   = '0;
            pulse_due[r]   = 1'b0;
        end
        tick_phase = '0;
        coil_pulse_q.delete();
    endtask

    task automatic switch_relay(input int r, input mode_t m);
        relay_state[r] = m;
        pulse_due[r]   = 1'b1;
    endtask

    // A tick advances the prescaler, counts timed relays down once per
    // second, and then emits one pulse for every relay whose mode was written.
    task automatic predict_tick();
        coil_masks_t masks;
        masks = '0;
        tick_phase = tick_phase + 1'b1;
        if (tick_phase > TICKS_PER_SECOND_LAST) begin
            tick_phase = '0;
            for (int r = 0; r < RELAY_COUNT; r++) begin
                if (relay_state[r] == MODE_TIMED && secs_left[r] != '0) begin
                    secs_left[r] = secs_left[r] - 1'b1;
                    if (secs_left[r] == '0)
                        switch_relay(r, MODE_OFF);
                end
            end
        end
        for (int r = 0; r < RELAY_COUNT; r++) begin
            if (pulse_due[r]) begin
                if (r < MASK_W) begin
                    if (relay_state[r] == MODE_ON || relay_state[r] == MODE_TIMED)
                        masks.on_mask[r] = 1'b1;
                    else
                        masks.off_mask[r] = 1'b1;
                end
                pulse_due[r] = 1'b0;
            end
        end
        coil_pulse_q.push_back(masks);
    endtask

    task automatic predict_command(input logic [2:0] req, input logic idx,
                                   input logic [SECONDS_W-1:0] secs);
        if (int'(idx) >= RELAY_COUNT)
            return;
        case (req)
            REQ_ON:     switch_relay(idx, MODE_ON);
            REQ_OFF:    switch_relay(idx, MODE_OFF);
            REQ_TOGGLE: switch_relay(idx, relay_state[idx] == MODE_ON ? MODE_OFF : MODE_ON);
            REQ_TIMER: begin
                if (secs == '0) begin
                    switch_relay(idx, MODE_OFF);
                end else if (secs == 1) begin
                    switch_relay(idx, MODE_ON);
                end else begin
                    secs_left[idx] = secs;
                    switch_relay(idx, MODE_TIMED);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        coil_masks_t want;
        if (!aresetn) begin
            clear_relays();
            error_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (coil_pulse_q.size() == 0) begin
                    $display("%0t: unexpected coil item, expected none, got on=%b off=%b",
                             $time, m_tdata[1:0], m_tdata[3:2]);
                    error_count++;
                end else begin
                    want = coil_pulse_q.pop_front();
                    if (m_tdata[1:0] !== want.on_mask) begin
                        $display("%0t: on_coil_mask expected %b, actual %b",
                                 $time, want.on_mask, m_tdata[1:0]);
                        error_count++;
                    end
                    if (m_tdata[3:2] !== want.off_mask) begin
                        $display("%0t: off_coil_mask expected %b, actual %b",
                                 $time, want.off_mask, m_tdata[3:2]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_TICK)
                    predict_tick();
                else
                    predict_command(s_tuser, s_tdata[0], s_tdata[16:1]);
            end
        end
        coils_outstanding = coil_pulse_q.size();
    end

endmodule

// File: tb/tb_latching_relay_timer_driver.sv
// Top of the relay driver testbench: clock, reset, directed and random
// request items, receiver stalls and the verdict. Needs lrtd_pkg, the block
// latching_relay_timer_driver and the checker lrtd_checker.
`timescale 1ns / 1ps

module tb_latching_relay_timer_driver;
    import lrtd_pkg::*;

    // Roughly 1850 items in total; the directed part takes about forty.
    localparam int RANDOM_ITEMS = 1825;
    // Worst case is far below this: every item after its longest gap and
    // every tick result held through the longest stall still fits easily.
    localparam int CYCLE_LIMIT  = 800000;
    // The block answers a tick from its result register; the drain then lets
    // any stray result show up before the verdict.
    localparam int DRAIN_CYCLES = 10;

    localparam logic [2:0] REQ_UNKNOWN_LO  = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_MID = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN_HI  = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [0] relay_index, [16:1] seconds, [23:17] zero
    logic [2:0]  s_tuser = '0;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [1:0] on_coil_mask, [3:2] off_coil_mask

    int error_count;
    int coils_outstanding;
    int cycle_count = 0;
    int items_sent = 0;
    // When set, the sender offers items back to back with no idle cycles.
    bit steady_input = 1'b0;

    latching_relay_timer_driver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lrtd_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .error_count       (error_count),
        .coils_outstanding (coils_outstanding)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle length before the next item: mostly none or short, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one item and returns right after the edge that accepted it.
    // The valid is lowered only when a gap follows, so back-to-back items
    // never see valid dropped and raised within one time step.
    task automatic send_item(input logic [2:0] req, input logic idx,
                             input logic [SECONDS_W-1:0] secs);
        int gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, secs, idx};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Ticks carry random index and seconds, which the block must ignore.
    task automatic send_tick();
        send_item(REQ_TICK, 1'($urandom), 16'($urandom));
    endtask

    // A random command. Timer loads favor a few seconds so that countdowns
    // actually expire between commands; full-range values keep every bit busy.
    task automatic send_random_command();
        int roll;
        logic [2:0] req;
        logic [SECONDS_W-1:0] secs;
        roll = $urandom_range(0, 99);
        secs = 16'($urandom);
        if (roll < 18) req = REQ_ON;
        else if (roll < 34) req = REQ_OFF;
        else if (roll < 54) req = REQ_TOGGLE;
        else if (roll < 93) req = REQ_TIMER;
        else req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        if (req == REQ_TIMER) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) secs = 16'($urandom_range(2, 4));
            else if (roll < 75) secs = 16'($urandom_range(0, 1));
            else if (roll < 92) secs = 16'($urandom_range(5, 12));
        end
        send_item(req, 1'($urandom), secs);
    endtask

    // The receiver alternates ready runs and stalls. Most stalls are short,
    // a few are long, and some stretches never stall at all.
    initial begin
        int stall;
        int run;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 99) < 15) begin
                stall = 0;
                run = $urandom_range(40, 150);
            end else begin
                stall = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 3)
                                                      : $urandom_range(15, 50);
                run = $urandom_range(1, 20);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
        end
    end

    initial begin
        int n_cmds;
        int n_ticks;

        // Synchronous reset, held from the start and never asserted again.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. A tick with nothing written pulses no coil.
        send_item(REQ_TICK, 1'b0, 16'h0000);
        send_item(REQ_ON, 1'b0, 16'hFFFF);
        send_item(REQ_ON, 1'b1, 16'h0000);
        send_item(REQ_TICK, 1'b1, 16'hFFFF);
        // Turning an on relay on again still marks it for a fresh pulse.
        send_item(REQ_ON, 1'b0, 16'h0000);
        send_item(REQ_OFF, 1'b1, 16'h5555);
        send_item(REQ_TICK, 1'b0, 16'hAAAA);
        // Toggle: on goes off, off goes on.
        send_item(REQ_TOGGLE, 1'b0, 16'h0000);
        send_item(REQ_TOGGLE, 1'b1, 16'hFFFF);
        send_item(REQ_TICK, 1'b0, 16'h0000);
        // Timer loads of zero and one act as off and on.
        send_item(REQ_TIMER, 1'b0, 16'd0);
        send_item(REQ_TIMER, 1'b1, 16'd1);
        send_item(REQ_TICK, 1'b0, 16'h0000);
        // Largest countdown, then toggle a timed relay, which turns it on.
        send_item(REQ_TIMER, 1'b0, 16'hFFFF);
        send_item(REQ_TIMER, 1'b1, 16'd2);
        send_item(REQ_TICK, 1'b0, 16'h0000);
        send_item(REQ_TOGGLE, 1'b0, 16'h1234);
        // Unknown request codes change nothing and give no result.
        send_item(REQ_UNKNOWN_LO, 1'b0, 16'hFFFF);
        send_item(REQ_UNKNOWN_MID, 1'b1, 16'h0000);
        send_item(REQ_UNKNOWN_HI, 1'b1, 16'd3);
        send_item(REQ_TICK, 1'b1, 16'h0000);
        // Relay 1 still counts down from two seconds: twenty-two more ticks
        // carry it across two second boundaries until it drops off.
        repeat (22) send_tick();

        // Random part: short bursts of commands, each followed by a run of
        // ticks long enough, at times, for loaded timers to run out.
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 15)
                steady_input = ~steady_input;
            n_cmds = $urandom_range(0, 3);
            n_ticks = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
                                                    : $urandom_range(15, 50);
            repeat (n_cmds) send_random_command();
            repeat (n_ticks) send_tick();
        end
        s_tvalid <= 1'b0;

        // Let the checker see the last acceptance, then wait for every
        // predicted coil item and a short drain for anything unexpected.
        @(posedge aclk);
        wait (coils_outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
